// ===== design/llss_pkg.sv =====
// ============================================================================
// llss_pkg
// Types and constants shared by the least-loaded server select unit.
// ============================================================================
package llss_pkg;

  // Field widths
  localparam int OP_W       = 2;
  localparam int PEER_W     = 4;
  localparam int TAG_W      = 8;
  localparam int COUNT_W    = 16;
  // Peer index width in tokens and bumps (256 values, but loads reach only 16 peers)
  localparam int PEER_IDX_W = 8;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REQUEST = 2'd1;
  localparam logic [OP_W-1:0] OP_DEAD    = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Input request
  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [PEER_W-1:0]  peer;
    logic [TAG_W-1:0]   content;
    logic [COUNT_W-1:0] start_load;
  } llss_item_t;

  // Result
  typedef struct packed {
    logic [PEER_W-1:0] server;
    logic              found;
  } llss_result_t;

  // Table write command broadcast to every cell
  typedef struct packed {
    logic               wr;
    logic               kill;
    logic [PEER_W-1:0]  peer;
    logic [TAG_W-1:0]   content;
    logic [COUNT_W-1:0] start_load;
  } llss_cmd_t;

  // Count increment broadcast to every cell
  typedef struct packed {
    logic                  en;
    logic [PEER_IDX_W-1:0] idx;
  } llss_bump_t;

  // Search token handed from cell to cell
  typedef struct packed {
    logic                  valid;
    logic                  have;
    logic [PEER_IDX_W-1:0] idx;
    logic [COUNT_W-1:0]    cnt;
    logic [TAG_W-1:0]      content;
  } llss_tok_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } llss_state_t;

endpackage

// ===== design/llss_cell.sv =====
// ============================================================================
// llss_cell
// One peer entry: tag, alive flag and served count, plus one search stage.
// ============================================================================
module llss_cell import llss_pkg::*; #(
  parameter int INDEX = 0
) (
  input  logic       clk,
  input  logic       rst,
  input  llss_cmd_t  cmd,
  input  llss_bump_t bump,
  input  llss_tok_t  tok_in,
  output llss_tok_t  tok_out
);

  logic [TAG_W-1:0]   tag;
  logic [COUNT_W-1:0] count;
  logic               alive;
  logic               sel;
  logic               bump_sel;
  logic               take;

  assign sel      = (32'(cmd.peer) == INDEX);
  assign bump_sel = bump.en && (32'(bump.idx) == INDEX);

  // Claim the token when this peer matches and beats the best so far
  assign take = tok_in.valid && alive && (tag == tok_in.content) &&
                (!tok_in.have || (count < tok_in.cnt));

  // Alive flag
  always_ff @(posedge clk) begin
    if (rst) begin
      alive <= 1'b0;
    end else if (cmd.wr && sel) begin
      alive <= 1'b1;
    end else if (cmd.kill && sel) begin
      alive <= 1'b0;
    end
  end

  // Tag and count: load writes, bump raises with saturation
  always_ff @(posedge clk) begin
    if (cmd.wr && sel) begin
      tag   <= cmd.content;
      count <= cmd.start_load;
    end else if (bump_sel && (count != COUNT_MAX)) begin
      count <= count + 1'b1;
    end
  end

  // Advance the token to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    tok_out.content <= tok_in.content;
    if (take) begin
      tok_out.have <= 1'b1;
      tok_out.idx  <= PEER_IDX_W'(INDEX);
      tok_out.cnt  <= count;
    end else begin
      tok_out.have <= tok_in.have;
      tok_out.idx  <= tok_in.idx;
      tok_out.cnt  <= tok_in.cnt;
    end
  end

endmodule

// ===== design/least_loaded_server_select_unit.sv =====
// ============================================================================
// least_loaded_server_select_unit
// Least-connections peer selection over a chain of peer cells.
// ============================================================================
//
//   channel   handshake          payload        direction
//   request   start / busy       item   (struct) in
//   result    done (strobe)      result (struct) out
//
// A content request walks the search token down the cell chain one cell per
// cycle; when it leaves the chain the result is loaded and done is shown
// for one cycle. Load, dead and unused operations respond without a scan.
// Synchronous reset clears every alive flag and idles the sequencer; tags
// and counts are written by load before they are read.
// The receiver cannot stall: done is high for exactly one cycle per request.
module least_loaded_server_select_unit import llss_pkg::*; #(
  parameter int PEERS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  llss_item_t   item,
  output logic         done,
  output llss_result_t result
);

  llss_state_t state, state_next;
  llss_tok_t   tok [PEERS+1];
  llss_cmd_t   cmd;
  llss_bump_t  bump;
  llss_tok_t   last;
  logic        accept;
  logic [PEERS-1:0] tok_v;

  assign accept = start && !busy;
  assign last   = tok[PEERS];

  // Broadcast table writes at accept
  always_comb begin
    cmd.wr         = accept && (item.operation == OP_LOAD);
    cmd.kill       = accept && (item.operation == OP_DEAD);
    cmd.peer       = item.peer;
    cmd.content    = item.content;
    cmd.start_load = item.start_load;
  end

  // Inject a fresh search token for a content request
  always_comb begin
    tok[0].valid   = accept && (item.operation == OP_REQUEST);
    tok[0].have    = 1'b0;
    tok[0].idx     = '0;
    tok[0].cnt     = '0;
    tok[0].content = item.content;
  end

  // Raise the winner's count as the token leaves the chain
  assign bump.en  = last.valid && last.have;
  assign bump.idx = last.idx;

  // Peer cells
  for (genvar i = 0; i < PEERS; i++) begin : g_cell
    llss_cell #(.INDEX(i)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .cmd    (cmd),
      .bump   (bump),
      .tok_in (tok[i]),
      .tok_out(tok[i+1])
    );
    assign tok_v[i] = tok[i+1].valid;
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and outputs
  always_comb begin
    state_next = state;
    busy       = 1'b1;
    done       = 1'b0;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_next = (item.operation == OP_REQUEST) ? ST_SCAN : ST_RESP;
        end
      end
      ST_SCAN: begin
        if (last.valid) begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold the result: cleared at accept, loaded when the token exits
  always_ff @(posedge clk) begin
    if (accept) begin
      result.server <= '0;
      result.found  <= 1'b0;
    end else if (last.valid) begin
      result.server <= last.have ? PEER_W'(last.idx) : '0;
      result.found  <= last.have;
    end
  end

  // At most one token in flight
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_v))
    else $error("more than one search token in the chain");

  // No token in flight while idle
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (tok_v == '0))
    else $error("search token present while idle");

  // An accepted request makes the unit busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("unit not busy after accepting a request");

  // The token only exits during a scan
  a_exit_scan: assert property (@(posedge clk) disable iff (rst)
    last.valid |-> (state == ST_SCAN))
    else $error("search token left the chain outside a scan");

endmodule
